// ===== rtl/ccu_pkg.sv =====
// Shared types and constants for the clock observation checker.
// No dependencies; imported by ccu_wall_delta and clock_observation_checker_unit.
`timescale 1ns / 1ps
`default_nettype none

package ccu_pkg;

    localparam int unsigned NS_PER_SEC = 1000000000;
    // Largest whole-second span whose product with NS_PER_SEC still fits in 64 bits
    localparam logic [63:0] SAT_QUOT   = 64'hFFFF_FFFF_FFFF_FFFF / 64'(NS_PER_SEC);
    localparam int          NS_W       = 30;
    localparam int          SEC_SPAN_W = 35;   // bits of a second span below SAT_QUOT

    localparam logic [2:0]  CFG_FC_REGRESSION = 3'd0;
    localparam logic [2:0]  CFG_FC_ROLLBACK   = 3'd1;
    localparam logic [2:0]  CFG_FC_FORWARD    = 3'd2;
    localparam logic [2:0]  CFG_MAX_BACKWARD  = 3'd3;
    localparam logic [2:0]  CFG_MAX_FORWARD   = 3'd4;

    typedef enum logic [2:0] {
        DEC_ACCEPTED   = 3'd0,
        DEC_INVALID    = 3'd1,
        DEC_REGRESSION = 3'd2,
        DEC_ROLLBACK   = 3'd3,
        DEC_FORWARD    = 3'd4
    } t_decision;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_WARNING = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/ccu_wall_delta.sv =====
// Saturating nanosecond distance between two wall clock readings.
// Depends on ccu_pkg (NS_PER_SEC, SAT_QUOT, widths).
`timescale 1ns / 1ps
`default_nettype none

module ccu_wall_delta
    import ccu_pkg::*;
(
    input  wire logic [63:0]     i_early_sec,
    input  wire logic [NS_W-1:0] i_early_ns,
    input  wire logic [63:0]     i_late_sec,
    input  wire logic [NS_W-1:0] i_late_ns,
    output logic      [63:0]     o_delta
);

    logic [63:0]   ds;
    logic [63:0]   ds_m1;
    logic signed [NS_W:0] dn;
    logic [NS_W:0] rem;
    logic [63:0]   base;
    logic [64:0]   sum;

    always_comb begin
        ds    = i_late_sec - i_early_sec;
        ds_m1 = ds - 64'd1;
        dn    = $signed({1'b0, i_late_ns}) - $signed({1'b0, i_early_ns});
        // one second borrowed from the span keeps the ns part positive
        rem   = (NS_W+1)'(NS_PER_SEC) + $unsigned(dn);
        base  = 64'(ds_m1[SEC_SPAN_W-1:0]) * 64'(NS_PER_SEC);
        sum   = {1'b0, base} + 65'(rem);
        if (ds == 64'd0) begin
            o_delta = (dn > 0) ? 64'($unsigned(dn)) : 64'd0;
        end else if (ds_m1 > SAT_QUOT || sum[64]) begin
            o_delta = '1;
        end else begin
            o_delta = sum[63:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clock_observation_checker_unit.sv =====
// Clock observation checker top level: input register, snapshot checks, result register.
// Depends on ccu_pkg and ccu_wall_delta.
//
//  channel   | dir | tdata fields (low bit first)                      | width
//  s_axis    | in  | mono_ticks[63:0] wall_seconds[127:64] wall_nanos[159:128] | 160
//  m_axis    | out | decision[2:0] status[4:3] accepted_count[68:5], zero pad | 72
//  cfg       | in  | i_cfg_we, i_cfg_idx (0..4), i_cfg_data (64)        | 64
//
// One request per cycle while not stalled; a request goes through the input register
// and then the result register. It is checked in one pass against the stored snapshot,
// updated unless rejected as its result is registered, so the next request sees it.
// Reset clears the configuration, the stored snapshot and the count.
// A stalled result holds in the output register; the input register keeps taking
// requests until both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module clock_observation_checker_unit
    import ccu_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // mono_ticks[63:0], wall_seconds[127:64], wall_nanos[159:128]
    input  wire logic [159:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // decision[2:0], status[4:3], accepted_count[68:5], zeros[71:69]
    output logic      [71:0]  o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [63:0]  i_cfg_data
);

    // configuration
    logic        r_fc_reg, r_fc_roll, r_fc_fwd;
    logic [63:0] r_max_back, r_max_fwd;

    // input register
    logic        r_in_valid;
    logic [63:0] r_in_mono;
    logic [63:0] r_in_sec;
    logic [31:0] r_in_ns;

    // stored snapshot
    logic            r_seen;
    logic [63:0]     r_last_mono;
    logic [63:0]     r_last_sec;
    logic [NS_W-1:0] r_last_ns;
    logic [63:0]     r_total;

    // result register
    logic        r_out_valid;
    t_decision   r_dec;
    t_status     r_st;
    logic [63:0] r_cnt;

    logic        out_move, in_move, in_take;
    logic        ns_bad, regress, wall_lt, wall_gt, roll, fwd_jump, keep;
    logic [63:0] elapsed, fwd_bound, delta;
    logic [63:0] early_sec, late_sec;
    logic [NS_W-1:0] in_ns30, early_ns, late_ns;
    t_decision   n_dec;
    t_status     n_st;
    logic [63:0] n_total;

    assign out_move        = !r_out_valid || i_m_axis_tready;
    assign in_move         = r_in_valid && out_move;
    assign o_s_axis_tready = !r_in_valid || out_move;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_cnt, r_st, r_dec};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_reg   <= 1'b0;
            r_fc_roll  <= 1'b0;
            r_fc_fwd   <= 1'b0;
            r_max_back <= '0;
            r_max_fwd  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FC_REGRESSION: r_fc_reg   <= i_cfg_data[0];
                CFG_FC_ROLLBACK:   r_fc_roll  <= i_cfg_data[0];
                CFG_FC_FORWARD:    r_fc_fwd   <= i_cfg_data[0];
                CFG_MAX_BACKWARD:  r_max_back <= i_cfg_data;
                CFG_MAX_FORWARD:   r_max_fwd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // checks on the registered snapshot
    assign in_ns30 = r_in_ns[NS_W-1:0];
    assign ns_bad  = r_in_ns >= 32'(NS_PER_SEC);
    assign regress = r_in_mono < r_last_mono;
    assign wall_lt = ($signed(r_in_sec) < $signed(r_last_sec)) ||
                     (r_in_sec == r_last_sec && in_ns30 < r_last_ns);
    assign wall_gt = ($signed(r_in_sec) > $signed(r_last_sec)) ||
                     (r_in_sec == r_last_sec && in_ns30 > r_last_ns);

    // one delta unit serves both directions
    assign early_sec = wall_lt ? r_in_sec   : r_last_sec;
    assign early_ns  = wall_lt ? in_ns30    : r_last_ns;
    assign late_sec  = wall_lt ? r_last_sec : r_in_sec;
    assign late_ns   = wall_lt ? r_last_ns  : in_ns30;

    ccu_wall_delta u_delta (
        .i_early_sec (early_sec),
        .i_early_ns  (early_ns),
        .i_late_sec  (late_sec),
        .i_late_ns   (late_ns),
        .o_delta     (delta)
    );

    assign elapsed   = regress ? 64'd0 : r_in_mono - r_last_mono;
    assign fwd_bound = elapsed + r_max_fwd;
    assign roll      = wall_lt && (r_max_back == 64'd0 || delta > r_max_back);
    assign fwd_jump  = wall_gt && r_max_fwd != 64'd0 && delta > fwd_bound;

    always_comb begin
        n_dec = DEC_ACCEPTED;
        n_st  = ST_OK;
        keep  = 1'b0;
        if (ns_bad) begin
            n_dec = DEC_INVALID;
            n_st  = ST_ERROR;
            keep  = 1'b1;
        end else if (!r_seen) begin
            n_dec = DEC_ACCEPTED;
            n_st  = ST_OK;
        end else if (regress && r_fc_reg) begin
            n_dec = DEC_REGRESSION;
            n_st  = ST_ERROR;
            keep  = 1'b1;
        end else if (roll) begin
            n_dec = DEC_ROLLBACK;
            n_st  = r_fc_roll ? ST_ERROR : ST_WARNING;
            keep  = r_fc_roll;
        end else if (fwd_jump) begin
            n_dec = DEC_FORWARD;
            n_st  = r_fc_fwd ? ST_ERROR : ST_WARNING;
            keep  = r_fc_fwd;
        end else if (regress) begin
            n_dec = DEC_REGRESSION;
            n_st  = ST_WARNING;
        end
        if (keep) begin
            n_total = r_total;
        end else if (!r_seen) begin
            n_total = 64'd1;
        end else begin
            n_total = r_total + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mono <= i_s_axis_tdata[63:0];
            r_in_sec  <= i_s_axis_tdata[127:64];
            r_in_ns   <= i_s_axis_tdata[159:128];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_mono <= '0;
            r_last_sec  <= '0;
            r_last_ns   <= '0;
            r_total     <= '0;
        end else if (in_move && !keep) begin
            r_seen      <= 1'b1;
            r_last_mono <= r_in_mono;
            r_last_sec  <= r_in_sec;
            r_last_ns   <= in_ns30;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_dec <= n_dec;
            r_st  <= n_st;
            r_cnt <= n_total;
        end
    end

    // an invalid nanosecond field always yields an invalid-wall error
    a_invalid_ns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && ns_bad |=> r_dec == DEC_INVALID && r_st == ST_ERROR)
        else $error("invalid nanoseconds not reported");

    // a rejected snapshot leaves the count untouched
    a_error_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && n_st == ST_ERROR |=> $stable(r_total) && $stable(r_last_mono))
        else $error("rejected snapshot changed stored state");

    // the reported count is the stored count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move |=> r_cnt == r_total)
        else $error("result count differs from stored count");

    // nothing is counted before the first snapshot is stored
    a_unseen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_total == 64'd0)
        else $error("count nonzero before first snapshot");

endmodule

`default_nettype wire

// ===== tb/clock_observation_checker_unit_tb.sv =====
// Self-checking bench for clock_observation_checker_unit: snapshot requests in,
// decision/status/count results out, compared against an in-bench predictor.
// Depends on ccu_pkg and the RTL of the checker unit.
`timescale 1ns / 1ps

module clock_observation_checker_unit_tb;
    import ccu_pkg::*;

    localparam longint    NANOS_PER_SEC = 1_000_000_000;
    localparam bit [63:0] SPAN_LIMIT    = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1_000_000_000;
    localparam longint    SEC_MIN       = 64'sh8000_0000_0000_0000;
    localparam longint    SEC_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Field order matches the request tdata layout, mono_ticks in the low bits
    typedef struct packed {
        bit        [31:0] nanos;
        bit signed [63:0] secs;
        bit        [63:0] mono;
    } t_snap;

    typedef struct {
        t_decision dec;
        t_status   st;
        bit [63:0] count;
    } t_verdict;

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // mono_ticks[63:0], wall_seconds[127:64], wall_nanos[159:128]
    logic [159:0] i_s_axis_tdata  = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // decision[2:0], status[4:3], accepted_count[68:5], zeros[71:69]
    logic [71:0]  o_m_axis_tdata;
    logic         i_cfg_we        = 1'b0;
    logic [2:0]   i_cfg_idx       = '0;
    logic [63:0]  i_cfg_data      = '0;

    // Predictor copy of the configuration and of the stored snapshot
    bit          cfg_fc_regression, cfg_fc_rollback, cfg_fc_forward;
    bit [63:0]   cfg_max_back, cfg_max_fwd;
    bit          have_first;
    bit [63:0]   kept_mono;
    longint      kept_secs;
    bit [29:0]   kept_ns;
    bit [63:0]   kept_count;

    t_verdict    expected_verdicts[$];
    int          mismatches, n_sent, n_checked, n_settings;
    int          decision_tally[5];
    int          gap_pct = 20, stall_pct = 20, hold_cycles;

    clock_observation_checker_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int gap_length(input int pct);
        if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // Saturating nanoseconds from (se,ne) forward to (sl,nl)
    function automatic bit [63:0] wall_span(input longint se, input bit [31:0] ne,
                                            input longint sl, input bit [31:0] nl);
        bit [63:0] ds, base, rem;
        longint    dn;
        ds = sl - se;
        dn = longint'({32'd0, nl}) - longint'({32'd0, ne});
        if (ds == 0) return (dn > 0) ? 64'(dn) : 64'd0;
        if (ds - 64'd1 > SPAN_LIMIT) return '1;
        base = (ds - 64'd1) * 64'd1_000_000_000;
        rem  = 64'(NANOS_PER_SEC + dn);
        if (rem > ~64'd0 - base) return '1;
        return base + rem;
    endfunction

    function automatic t_verdict judge_snapshot(input t_snap s);
        t_verdict  v;
        bit [63:0] span, elapsed;
        bit        earlier, later;
        v.dec   = DEC_ACCEPTED;
        v.st    = ST_OK;
        v.count = kept_count;
        if (s.nanos >= NANOS_PER_SEC) begin
            v.dec = DEC_INVALID;
            v.st  = ST_ERROR;
            return v;
        end
        if (!have_first) begin
            have_first = 1'b1;
            kept_mono  = s.mono;
            kept_secs  = s.secs;
            kept_ns    = s.nanos[29:0];
            kept_count = 64'd1;
            v.count    = kept_count;
            return v;
        end
        if (s.mono < kept_mono) begin
            v.dec = DEC_REGRESSION;
            v.st  = cfg_fc_regression ? ST_ERROR : ST_WARNING;
            if (cfg_fc_regression) return v;
        end
        earlier = (s.secs < kept_secs) || (s.secs == kept_secs && s.nanos < kept_ns);
        later   = (s.secs > kept_secs) || (s.secs == kept_secs && s.nanos > kept_ns);
        if (earlier) begin
            span = wall_span(s.secs, s.nanos, kept_secs, 32'(kept_ns));
            if (cfg_max_back == 0 || span > cfg_max_back) begin
                v.dec = DEC_ROLLBACK;
                v.st  = cfg_fc_rollback ? ST_ERROR : ST_WARNING;
                if (cfg_fc_rollback) return v;
            end
        end else if (later && cfg_max_fwd != 0) begin
            span    = wall_span(kept_secs, 32'(kept_ns), s.secs, s.nanos);
            elapsed = (s.mono >= kept_mono) ? s.mono - kept_mono : 64'd0;
            // the bound wraps at 64 bits
            if (span > elapsed + cfg_max_fwd) begin
                v.dec = DEC_FORWARD;
                v.st  = cfg_fc_forward ? ST_ERROR : ST_WARNING;
                if (cfg_fc_forward) return v;
            end
        end
        kept_mono  = s.mono;
        kept_secs  = s.secs;
        kept_ns    = s.nanos[29:0];
        kept_count = kept_count + 64'd1;
        v.count    = kept_count;
        return v;
    endfunction

    function automatic t_snap snapshot_of(input bit [63:0] m, input longint sec,
                                          input bit [31:0] n);
        t_snap s;
        s.mono  = m;
        s.secs  = sec;
        s.nanos = n;
        return s;
    endfunction

    // Move the wall time by a signed number of nanoseconds, keeping nanos normalized
    function automatic t_snap shift_wall(input t_snap base, input longint delta);
        t_snap  s;
        longint n;
        s      = base;
        s.secs = base.secs + delta / NANOS_PER_SEC;
        n      = longint'({32'd0, base.nanos}) + delta % NANOS_PER_SEC;
        if (n < 0) begin
            n      = n + NANOS_PER_SEC;
            s.secs = s.secs - 1;
        end else if (n >= NANOS_PER_SEC) begin
            n      = n - NANOS_PER_SEC;
            s.secs = s.secs + 1;
        end
        s.nanos = 32'(n);
        return s;
    endfunction

    // An amount within one of a configured limit, or a plain random one if the limit is huge
    function automatic longint near_limit(input bit [63:0] lim);
        if (lim > (64'd1 << 40)) return longint'($urandom_range(1, 32'hFFFF_FFFF));
        return longint'(lim) + longint'($urandom_range(0, 2)) - 1;
    endfunction

    // Mostly plausible clock progress from the stored snapshot, with anomalies and noise
    function automatic t_snap pick_snapshot();
        t_snap  s, base;
        longint el, amt, jitter;
        int     kind;
        base   = snapshot_of(kept_mono, kept_secs, {2'b00, kept_ns});
        el     = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 32'd3_000_000_000))
                                             : longint'($urandom_range(0, 5000));
        jitter = longint'($urandom_range(0, 200)) - 100;
        kind   = $urandom_range(0, 99);
        if (!have_first || kind < 8) begin
            s.mono  = {$urandom, $urandom};
            s.secs  = {$urandom, $urandom};
            s.nanos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999_999_999);
        end else if (kind < 13) begin
            s       = shift_wall(base, el);
            s.mono  = base.mono + el;
            s.nanos = $urandom_range(32'd1_000_000_000, 32'hFFFF_FFFF);
        end else if (kind < 25) begin
            s      = shift_wall(base, el + jitter);
            s.mono = base.mono - 64'($urandom_range(1, 5000));
        end else if (kind < 40) begin
            amt = near_limit(cfg_max_back);
            if (amt < 1) amt = 1;
            s      = shift_wall(base, -amt);
            s.mono = base.mono + el;
        end else if (kind < 55) begin
            amt    = near_limit(cfg_max_fwd);
            s      = shift_wall(base, el + amt);
            s.mono = base.mono + el;
        end else if (kind < 60) begin
            s      = base;
            s.mono = ($urandom_range(0, 1) == 0) ? base.mono + el : base.mono - el;
        end else begin
            s      = shift_wall(base, el + jitter);
            s.mono = base.mono + el;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic send_snapshot(input t_snap s);
        int       gap;
        t_verdict v;
        gap = gap_length(gap_pct);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        v = judge_snapshot(s);
        expected_verdicts.insert(expected_verdicts.size(), v);
        n_sent++;
    endtask

    // Hold requests until every pending result is back and the pipeline is empty
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input bit fc_reg, input bit fc_rb, input bit fc_fwd,
                                 input bit [63:0] back, input bit [63:0] fwd);
        bit [63:0] upper_noise;
        // only bit 0 of a flag register counts
        upper_noise = {$urandom, $urandom} & ~64'd1;
        wait_idle();
        put_reg(CFG_FC_REGRESSION, upper_noise | 64'(fc_reg));
        put_reg(CFG_FC_ROLLBACK, upper_noise | 64'(fc_rb));
        put_reg(CFG_FC_FORWARD, upper_noise | 64'(fc_fwd));
        put_reg(CFG_MAX_BACKWARD, back);
        put_reg(CFG_MAX_FORWARD, fwd);
        // an unused index must leave everything alone
        put_reg(CFG_MAX_FORWARD + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        i_cfg_we          <= 1'b0;
        cfg_fc_regression = fc_reg;
        cfg_fc_rollback   = fc_rb;
        cfg_fc_forward    = fc_fwd;
        cfg_max_back      = back;
        cfg_max_fwd       = fwd;
        n_settings++;
    endtask

    // Reset values of the registers: invalid nanos before any snapshot, then the first one
    task automatic test_first_snapshot();
        send_snapshot(snapshot_of(64'd500, 10, 32'd1_000_000_000));
        send_snapshot(snapshot_of('1, -1, 32'hFFFF_FFFF));
        send_snapshot(snapshot_of(64'd0, 0, 32'd0));
        send_snapshot(snapshot_of(64'd100, 0, 32'd0));
        send_snapshot(snapshot_of(64'd200, 0, 32'd999_999_999));
    endtask

    task automatic test_default_warnings();
        send_snapshot(snapshot_of(64'd150, 1, 32'd0));
        send_snapshot(snapshot_of(64'd300, 0, 32'd999_999_998));
        // regression then rollback: the rollback decision wins
        send_snapshot(snapshot_of(64'd100, -5, 32'd0));
        send_snapshot(snapshot_of(64'd1_000_000, 1_000_000, 32'd0));
    endtask

    task automatic test_fail_closed_limits();
        load_settings(1'b0, 1'b1, 1'b1, 64'd5000, 64'd1000);
        send_snapshot(snapshot_of(64'd1_000_100, 999_999, 32'd999_995_000));
        send_snapshot(snapshot_of(64'd1_000_200, 999_999, 32'd999_989_999));
        send_snapshot(snapshot_of(64'd1_000_300, 1_000_000, 32'd0));
        send_snapshot(snapshot_of(64'd1_005_000, 1_000_000, 32'd0));
        // regression warning overridden by a forward error
        send_snapshot(snapshot_of(64'd1_004_000, 1_000_000, 32'd1_002));
        send_snapshot(snapshot_of(64'd1_004_000, 1_000_000, 32'd1_000));
    endtask

    task automatic test_saturation_extremes();
        load_settings(1'b1, 1'b0, 1'b0, '1, '1);
        send_snapshot(snapshot_of(64'd0, 1_000_000, 32'd1_000));
        send_snapshot(snapshot_of(64'd2_000_000, SEC_MIN, 32'd0));
        // saturated forward span against a bound that wraps to zero
        send_snapshot(snapshot_of(64'd2_000_001, SEC_MAX, 32'd999_999_999));
        send_snapshot(snapshot_of('1, SEC_MAX, 32'd999_999_999));
        send_snapshot(snapshot_of('1, SEC_MAX - 1, 32'd0));
    endtask

    task automatic test_streaming_no_gaps();
        gap_pct   = 0;
        stall_pct = 0;
        load_settings(1'b0, 1'b0, 1'b0, 64'd1000, 64'd500);
        repeat (50) send_snapshot(pick_snapshot());
        wait_idle();
        repeat (50) send_snapshot(pick_snapshot());
    endtask

    task automatic test_random_settings();
        bit [63:0] back, fwd;
        for (int ph = 0; ph < 5; ph++) begin
            gap_pct   = $urandom_range(10, 50);
            stall_pct = $urandom_range(10, 50);
            case (ph)
                0: begin
                    back = 64'd1_000_000;
                    fwd  = 64'd1_000_000;
                end
                1: begin
                    back = 64'd0;
                    fwd  = 64'd0;
                end
                2: begin
                    back = '1;
                    fwd  = '1;
                end
                3: begin
                    back = 64'($urandom_range(0, 32'd2_000_000_000));
                    fwd  = 64'($urandom_range(0, 32'd2_000_000_000));
                end
                default: begin
                    back = {$urandom, $urandom};
                    fwd  = {$urandom, $urandom};
                end
            endcase
            if (ph == 0) begin
                load_settings(1'b1, 1'b1, 1'b1, back, fwd);
            end else begin
                load_settings(1'($urandom), 1'($urandom), 1'($urandom), back, fwd);
            end
            repeat (100) send_snapshot(pick_snapshot());
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_axis_tdata[63:0], 64'd0);
            end else begin
                want = expected_verdicts.pop_front();
                n_checked++;
                if (!$isunknown(o_m_axis_tdata[2:0]) && o_m_axis_tdata[2:0] <= DEC_FORWARD)
                    decision_tally[o_m_axis_tdata[2:0]]++;
                if (o_m_axis_tdata[2:0] !== want.dec)
                    report_mismatch("decision", o_m_axis_tdata[2:0], want.dec);
                if (o_m_axis_tdata[4:3] !== want.st)
                    report_mismatch("status", o_m_axis_tdata[4:3], want.st);
                if (o_m_axis_tdata[68:5] !== want.count)
                    report_mismatch("accepted_count", o_m_axis_tdata[68:5], want.count);
            end
        end
        // receiver back-pressure
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            hold_cycles = gap_length(stall_pct);
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_snapshot();
        test_default_warnings();
        test_fail_closed_limits();
        test_saturation_extremes();
        test_streaming_no_gaps();
        test_random_settings();

        i_s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 100_000 && expected_verdicts.size() != 0; w++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (expected_verdicts.size() != 0)
            report_mismatch("results never delivered", 64'(expected_verdicts.size()), 64'd0);

        $display("Checked %0d results for %0d snapshots under %0d register settings",
                 n_checked, n_sent, n_settings);
        $display("Decisions: accepted %0d, invalid %0d, regression %0d, rollback %0d, forward %0d",
                 decision_tally[0], decision_tally[1], decision_tally[2],
                 decision_tally[3], decision_tally[4]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
